// ===== hdl/aet_pkg.sv =====
// package: types, codes and defaults of the adjacency edge table unit
`default_nettype none
package aet_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_DEGREE_DEF   = 16;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_REM   = 3'd1,
    OP_QRY   = 3'd2,
    OP_LIST  = 3'd3,
    OP_RMV   = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMV0,
    S_LEN,
    S_LENW,
    S_RD,
    S_CMP,
    S_FIN,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] src;
    logic [5:0] tgt;
    logic       bad;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

endpackage
`default_nettype wire

// ===== hdl/aet_if.sv =====
// interfaces: input item channel and result item channel
`default_nettype none
interface aet_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [5:0] source_vertex;
  logic [5:0] target_vertex;
  modport source (output valid, opcode, source_vertex, target_vertex, input ready);
  modport sink (input valid, opcode, source_vertex, target_vertex, output ready);
endinterface

interface aet_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       edge_found;
  logic [5:0] neighbor;
  logic       neighbor_valid;
  logic       last;
  modport source (output valid, status, edge_found, neighbor, neighbor_valid, last,
                  input ready);
  modport sink (input valid, status, edge_found, neighbor, neighbor_valid, last,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/adjacency_edge_table_unit.sv =====
// top level: adjacency edge table unit
// Directed edge table with one ordered successor list per vertex. Items are
// queued by a two-entry front queue and carried out one at a time by the
// back end, which walks the successor memory one entry at a time: it reads
// each entry (S_RD) and then compares it (S_CMP). List gives one result
// item per entry, or one result item for an empty list; remove vertex walks
// the list of each known vertex. A result that waits on the output stalls
// the back end when the next result is due. Every item ends with one result
// item that has last set.
// The output register lets the next item be taken while a result waits.
`default_nettype none
module adjacency_edge_table_unit #(
  parameter int unsigned MAX_VERTICES = aet_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE   = aet_pkg::MAX_DEGREE_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aet_in_if.sink    in_i,
  aet_out_if.source out_o
);
  import aet_pkg::*;

  queue_t q;
  logic   pop;

  aet_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q),
    .pop_i  (pop)
  );

  aet_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .pop_o  (pop),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire

// ===== hdl/aet_front.sv =====
// front end: accepts items, checks vertex ranges and queues them
`default_nettype none
module aet_front #(
  parameter int unsigned MAX_VERTICES = aet_pkg::MAX_VERTICES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  aet_in_if.sink             in_i,
  output aet_pkg::queue_t    q_o,
  input  wire logic          pop_i
);
  import aet_pkg::*;

  item_t       buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;
  logic        src_bad, tgt_bad;
  item_t       cls;

  always_comb begin
    src_bad = {26'd0, in_i.source_vertex} >= 32'(MAX_VERTICES);
    tgt_bad = {26'd0, in_i.target_vertex} >= 32'(MAX_VERTICES);
    cls.op  = op_e'(in_i.opcode);
    cls.src = in_i.source_vertex;
    cls.tgt = in_i.target_vertex;
    case (cls.op)
      OP_ADD, OP_REM, OP_QRY: cls.bad = src_bad || tgt_bad;
      OP_LIST, OP_RMV:        cls.bad = src_bad;
      default:                cls.bad = 1'b0;
    endcase
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.item   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/aet_back.sv =====
// back end: walks the successor lists and produces result items
`default_nettype none
module aet_back #(
  parameter int unsigned MAX_VERTICES = aet_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_DEGREE   = aet_pkg::MAX_DEGREE_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire aet_pkg::queue_t  q_i,
  output logic                  pop_o,
  aet_out_if.source             out_o
);
  import aet_pkg::*;

  localparam int unsigned RW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned LW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned AW = (MAX_VERTICES * MAX_DEGREE > 1) ?
                               $clog2(MAX_VERTICES * MAX_DEGREE) : 1;
  localparam int unsigned NE = MAX_VERTICES * MAX_DEGREE;
  localparam logic [AW-1:0] DEG_A = AW'(MAX_DEGREE);
  localparam logic [LW-1:0] DEG_L = LW'(MAX_DEGREE);

  function automatic logic [AW-1:0] addr(input logic [RW-1:0] row, input logic [LW-1:0] idx);
    addr = AW'(row) * DEG_A + AW'(idx);
  endfunction

  logic [5:0]    st_mem [NE];
  logic [5:0]    st_rd_q;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [5:0]    st_wd;

  logic [LW-1:0] len_mem [MAX_VERTICES];
  logic [LW-1:0] len_rd_q;
  logic          len_vld_q [MAX_VERTICES];
  logic          len_we;
  logic [LW-1:0] len_wd;
  logic          clr_all;

  state_e        state_q, state_d, ret_q, ret_d;
  op_e           op_q, op_d;
  logic [5:0]    tgt_q, tgt_d;
  logic [RW-1:0] src_q, src_d, row_q, row_d;
  logic [LW-1:0] len_q, len_d, k_q, k_d, k_nx;
  logic          found_q, found_d, shift_q, shift_d;
  logic [CW-1:0] vcnt_q, vcnt_d;

  logic [1:0]    rs_q, rs_d;
  logic          rf_q, rf_d, rnv_q, rnv_d, rl_q, rl_d;
  logic [5:0]    rn_q, rn_d;

  logic          ov_q, out_load, out_free;
  logic [1:0]    os_q;
  logic          of_q, onv_q, ol_q;
  logic [5:0]    on_q;
  logic [LW-1:0] l_eff;
  logic [5:0]    d;
  logic          k_end;

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wd;
    st_rd_q <= st_mem[addr(row_q, k_q)];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) len_mem[row_q] <= len_wd;
    len_rd_q <= len_mem[row_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_VERTICES); i++) len_vld_q[i] <= 1'b0;
    end else if (clr_all) begin
      for (int i = 0; i < int'(MAX_VERTICES); i++) len_vld_q[i] <= 1'b0;
    end else if (len_we) begin
      len_vld_q[row_q] <= 1'b1;
    end
  end

  assign out_free = !ov_q || out_o.ready;
  assign d        = st_rd_q;
  assign k_nx     = k_q + LW'(1);
  assign k_end    = (k_nx == len_q);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    op_d     = op_q;
    tgt_d    = tgt_q;
    src_d    = src_q;
    row_d    = row_q;
    len_d    = len_q;
    k_d      = k_q;
    found_d  = found_q;
    shift_d  = shift_q;
    vcnt_d   = vcnt_q;
    rs_d     = rs_q;
    rf_d     = rf_q;
    rn_d     = rn_q;
    rnv_d    = rnv_q;
    rl_d     = rl_q;
    pop_o    = 1'b0;
    st_we    = 1'b0;
    st_waddr = addr(row_q, len_q);
    st_wd    = tgt_q;
    len_we   = 1'b0;
    len_wd   = len_q;
    clr_all  = 1'b0;
    out_load = 1'b0;
    l_eff    = '0;
    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o   = 1'b1;
          op_d    = q_i.item.op;
          tgt_d   = q_i.item.tgt;
          src_d   = RW'(q_i.item.src);
          row_d   = RW'(q_i.item.src);
          k_d     = '0;
          found_d = 1'b0;
          shift_d = 1'b0;
          rs_d    = ST_OK;
          rf_d    = 1'b0;
          rn_d    = '0;
          rnv_d   = 1'b0;
          rl_d    = 1'b1;
          ret_d   = S_IDLE;
          if (q_i.item.bad) begin
            rs_d    = ST_RANGE;
            state_d = S_OUT;
          end else begin
            case (q_i.item.op)
              OP_ADD: begin
                if (vcnt_q < CW'(q_i.item.src) + CW'(1)) vcnt_d = CW'(q_i.item.src) + CW'(1);
                state_d = S_LEN;
              end
              OP_REM, OP_QRY, OP_LIST: state_d = S_LEN;
              OP_RMV: begin
                tgt_d   = q_i.item.src;
                state_d = S_RMV0;
              end
              OP_CLEAR: begin
                vcnt_d  = '0;
                clr_all = 1'b1;
                state_d = S_OUT;
              end
              default: state_d = S_OUT;
            endcase
          end
        end
      end
      S_RMV0: begin
        if (CW'(src_q) < vcnt_q) begin
          len_we = 1'b1;
          len_wd = '0;
        end
        row_d   = '0;
        state_d = (vcnt_q == '0) ? S_OUT : S_LEN;
      end
      S_LEN: state_d = S_LENW;
      S_LENW: begin
        l_eff = len_vld_q[row_q] ? len_rd_q : '0;
        if (op_q != OP_ADD && op_q != OP_RMV && !(CW'(src_q) < vcnt_q)) l_eff = '0;
        len_d   = l_eff;
        k_d     = '0;
        found_d = 1'b0;
        shift_d = 1'b0;
        state_d = (l_eff == '0) ? S_FIN : S_RD;
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        case (op_q)
          OP_LIST: begin
            rs_d    = ST_OK;
            rf_d    = 1'b0;
            rn_d    = d;
            rnv_d   = 1'b1;
            rl_d    = k_end;
            k_d     = k_nx;
            ret_d   = k_end ? S_IDLE : S_RD;
            state_d = S_OUT;
          end
          OP_ADD, OP_QRY: begin
            if (d == tgt_q) begin
              found_d = 1'b1;
              state_d = S_FIN;
            end else begin
              k_d     = k_nx;
              state_d = k_end ? S_FIN : S_RD;
            end
          end
          default: begin
            if (shift_q) begin
              st_we    = 1'b1;
              st_waddr = addr(row_q, k_q - LW'(1));
              st_wd    = d;
            end else if (d == tgt_q) begin
              shift_d = 1'b1;
            end
            k_d     = k_nx;
            state_d = k_end ? S_FIN : S_RD;
          end
        endcase
      end
      S_FIN: begin
        rs_d    = ST_OK;
        rf_d    = 1'b0;
        rn_d    = '0;
        rnv_d   = 1'b0;
        rl_d    = 1'b1;
        ret_d   = S_IDLE;
        state_d = S_OUT;
        case (op_q)
          OP_ADD: begin
            if (!found_q) begin
              if (len_q == DEG_L) begin
                rs_d = ST_FULL;
              end else begin
                st_we  = 1'b1;
                len_we = 1'b1;
                len_wd = len_q + LW'(1);
              end
            end
          end
          OP_QRY: rf_d = found_q;
          OP_REM: begin
            if (shift_q) begin
              len_we = 1'b1;
              len_wd = len_q - LW'(1);
            end
          end
          OP_RMV: begin
            if (shift_q) begin
              len_we = 1'b1;
              len_wd = len_q - LW'(1);
            end
            row_d = row_q + RW'(1);
            if (CW'(row_q) + CW'(1) != vcnt_q) state_d = S_LEN;
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      vcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      vcnt_q  <= vcnt_d;
      if (out_load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tgt_q   <= tgt_d;
    src_q   <= src_d;
    row_q   <= row_d;
    len_q   <= len_d;
    k_q     <= k_d;
    found_q <= found_d;
    shift_q <= shift_d;
    rs_q    <= rs_d;
    rf_q    <= rf_d;
    rn_q    <= rn_d;
    rnv_q   <= rnv_d;
    rl_q    <= rl_d;
    if (out_load) begin
      os_q  <= rs_q;
      of_q  <= rf_q;
      on_q  <= rn_q;
      onv_q <= rnv_q;
      ol_q  <= rl_q;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.status         = os_q;
  assign out_o.edge_found     = of_q;
  assign out_o.neighbor       = on_q;
  assign out_o.neighbor_valid = onv_q;
  assign out_o.last           = ol_q;
endmodule
`default_nettype wire
